[rtl/gwf_pkg.sv]
// ----------------------------------------------------------------------------
// gwf_pkg: shared definitions for the grid wall follower
// Grid size, cell word layout, status codes, operation codes and move
// directions.
// ----------------------------------------------------------------------------
package gwf_pkg;

  localparam int SIDE    = 12;
  localparam int CELLS   = SIDE * SIDE;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COORD_W = 4;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;

  // One grid cell as it sits in the grid memory.
  typedef struct packed {
    logic wall;
    logic visited;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_STEP   = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EXIT        = 3'd1,
    ST_ENTRANCE    = 3'd2,
    ST_NO_ENTRY    = 3'd3,
    ST_NOT_STARTED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_DOWN  = 3'd1,
    DIR_RIGHT = 3'd2,
    DIR_UP    = 3'd3,
    DIR_LEFT  = 3'd4
  } dir_t;

endpackage

[rtl/grid_wall_follower_step.sv]
// ----------------------------------------------------------------------------
// grid_wall_follower_step: right-hand wall follower on a square grid
// A small sequencer drives one shared address unit and one grid memory.
// ----------------------------------------------------------------------------
// Each request passes from IDLE through its working states to DONE: load through
// LOAD, step through STEP and, where needed, ENT1 and ENT2 or NB, and start through
// SCAN (one memory read per column-0 row between the corners) and FOUND.
// s_tready is low while a request is being worked on, and one finished result may
// wait in the output register while the next request is accepted.
// Reset (rst, synchronous): walker at row 0, column 0, heading 0, not started,
// no result pending. The grid memory is not cleared; cells are written by
// load requests.
module grid_wall_follower_step
  import gwf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // s_tdata from bit 0 up: cell_row[3:0], cell_col[7:4], is_wall[8], zeros.
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // s_tuser from bit 0 up: opcode[1:0].
  input  logic [IN_TUSER_W-1:0]  s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // m_tdata from bit 0 up: pos_row[3:0], pos_col[7:4], heading[9:8],
  // moved[10], status[13:11], zeros.
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  // Sequencer states. Each request enters from IDLE and leaves through DONE,
  // which hands the result to the output register.
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOAD  = 9'b000000010,
    S_SCAN  = 9'b000000100,
    S_FOUND = 9'b000001000,
    S_STEP  = 9'b000010000,
    S_ENT1  = 9'b000100000,
    S_ENT2  = 9'b001000000,
    S_NB    = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  localparam logic [COORD_W-1:0] LAST = COORD_W'(SIDE - 1);

  state_t             state;

  // Walker state.
  logic [COORD_W-1:0] walker_row;
  logic [COORD_W-1:0] walker_col;
  logic [1:0]         walker_heading;
  logic               started;

  // The request being worked on.
  opcode_t            item_op;
  logic [COORD_W-1:0] item_row;
  logic [COORD_W-1:0] item_col;
  logic               item_wall;

  // Entrance scan bookkeeping.
  logic [COORD_W-1:0] scan_row;
  logic               rd_valid;
  logic [COORD_W-1:0] rd_row;
  logic [COORD_W-1:0] found_row;
  logic               found_any;

  // Result fields that are not taken straight from the walker state.
  logic               res_moved;
  status_t            res_status;

  // Shared address unit and grid memory hookup.
  logic [COORD_W-1:0] alu_row;
  logic [COORD_W-1:0] alu_col;
  dir_t               alu_dir;
  logic [COORD_W-1:0] tgt_row;
  logic [COORD_W-1:0] tgt_col;
  logic [ADDR_W-1:0]  ram_addr;
  logic               ram_we;
  cell_t              ram_wcell;
  logic [CELL_W-1:0]  ram_rdata;
  cell_t              rd_cell;

  dir_t               heading_dir;
  logic               on_edge;
  logic               load_ok;

  assign rd_cell  = cell_t'(ram_rdata);
  assign s_tready = (state == S_IDLE);

  // The walker looks below, right, above or left for headings 0 to 3.
  always_comb begin
    case (walker_heading)
      2'd0:    heading_dir = DIR_DOWN;
      2'd1:    heading_dir = DIR_RIGHT;
      2'd2:    heading_dir = DIR_UP;
      default: heading_dir = DIR_LEFT;
    endcase
  end

  assign on_edge = (walker_row == '0) || (walker_row == LAST) ||
                   (walker_col == '0) || (walker_col == LAST);

  assign load_ok = ({1'b0, item_row} < (COORD_W + 1)'(SIDE)) &&
                   ({1'b0, item_col} < (COORD_W + 1)'(SIDE));

  // Operand selection for the shared unit and the memory port.
  always_comb begin
    alu_row   = walker_row;
    alu_col   = walker_col;
    alu_dir   = DIR_NONE;
    ram_we    = 1'b0;
    ram_wcell = '{wall: 1'b0, visited: 1'b1};
    case (state)
      S_LOAD: begin
        alu_row   = item_row;
        alu_col   = item_col;
        ram_we    = (item_op == OP_LOAD) && load_ok;
        ram_wcell = '{wall: item_wall, visited: 1'b0};
      end
      S_SCAN: begin
        alu_row = scan_row;
        alu_col = '0;
      end
      S_FOUND: begin
        // The entrance cell is open, so only the visited mark changes.
        alu_row = found_row;
        alu_col = '0;
        ram_we  = found_any;
      end
      S_STEP: begin
        // Column 0 reads the walker's own cell, elsewhere the neighbor.
        alu_dir = (walker_col == '0) ? DIR_NONE : heading_dir;
      end
      S_ENT1: begin
        alu_dir = DIR_RIGHT;
      end
      S_ENT2: begin
        alu_dir = DIR_RIGHT;
        ram_we  = !rd_cell.wall && !rd_cell.visited;
      end
      S_NB: begin
        alu_dir = heading_dir;
        ram_we  = !rd_cell.wall;
      end
      default: ;
    endcase
  end

  gwf_addr_unit u_addr (
    .base_row (alu_row),
    .base_col (alu_col),
    .dir      (alu_dir),
    .tgt_row  (tgt_row),
    .tgt_col  (tgt_col),
    .addr     (ram_addr)
  );

  gwf_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wcell),
    .rdata (ram_rdata)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      walker_row     <= '0;
      walker_col     <= '0;
      walker_heading <= '0;
      started        <= 1'b0;
      m_tvalid       <= 1'b0;
      rd_valid       <= 1'b0;
    end else begin
      // DONE refills the output register itself when it hands over a result.
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            item_op    <= opcode_t'(s_tuser[1:0]);
            item_row   <= s_tdata[3:0];
            item_col   <= s_tdata[7:4];
            item_wall  <= s_tdata[8];
            res_moved  <= 1'b0;
            scan_row   <= COORD_W'(1);
            rd_valid   <= 1'b0;
            found_any  <= 1'b0;
            case (opcode_t'(s_tuser[1:0]))
              OP_START: state <= S_SCAN;
              OP_STEP:  state <= S_STEP;
              default:  state <= S_LOAD;
            endcase
          end
        end
        S_LOAD: begin
          res_status <= started ? ST_OK : ST_NOT_STARTED;
          state      <= S_DONE;
        end
        S_SCAN: begin
          // Reads are issued one row a cycle; each result lands in the cycle after its read.
          if (rd_valid && !rd_cell.wall) begin
            found_row <= rd_row;
            found_any <= 1'b1;
          end
          if (scan_row != LAST) begin
            rd_valid <= 1'b1;
            rd_row   <= scan_row;
            scan_row <= scan_row + COORD_W'(1);
          end else begin
            rd_valid <= 1'b0;
            if (rd_valid) begin
              state <= S_FOUND;
            end
          end
        end
        S_FOUND: begin
          if (found_any) begin
            walker_row     <= found_row;
            walker_col     <= '0;
            walker_heading <= '0;
            started        <= 1'b1;
            res_status     <= ST_OK;
          end else begin
            started    <= 1'b0;
            res_status <= ST_NO_ENTRY;
          end
          state <= S_DONE;
        end
        S_STEP: begin
          if (!started) begin
            res_status <= ST_NOT_STARTED;
            state      <= S_DONE;
          end else if (walker_col == '0) begin
            state <= S_ENT1;
          end else if (on_edge) begin
            res_status <= ST_EXIT;
            state      <= S_DONE;
          end else begin
            state <= S_NB;
          end
        end
        S_ENT1: begin
          // A column-0 cell that was never entered counts as an exit.
          if (rd_cell.visited) begin
            state <= S_ENT2;
          end else begin
            res_status <= ST_EXIT;
            state      <= S_DONE;
          end
        end
        S_ENT2: begin
          if (!rd_cell.wall && !rd_cell.visited) begin
            walker_col <= tgt_col;
            res_moved  <= 1'b1;
            res_status <= ST_OK;
          end else begin
            res_status <= ST_ENTRANCE;
          end
          state <= S_DONE;
        end
        S_NB: begin
          if (!rd_cell.wall) begin
            walker_row     <= tgt_row;
            walker_col     <= tgt_col;
            // Entering below, right, above or left sets heading 3, 0, 1 or 2.
            walker_heading <= walker_heading - 2'd1;
            res_moved      <= 1'b1;
          end else begin
            walker_heading <= walker_heading + 2'd1;
          end
          res_status <= ST_OK;
          state      <= S_DONE;
        end
        S_DONE: begin
          // Wait here only while an earlier result is still not taken.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, res_status, res_moved, walker_heading,
                         walker_col, walker_row};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/gwf_ram.sv]
// ----------------------------------------------------------------------------
// gwf_ram: generic single-port RAM
// One access per cycle; the read data is registered, the old word on a write.
// ----------------------------------------------------------------------------
module gwf_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/gwf_addr_unit.sv]
// ----------------------------------------------------------------------------
// gwf_addr_unit: shared coordinate and address unit
// Offsets a base cell by one move and forms the linear grid address.
// ----------------------------------------------------------------------------
module gwf_addr_unit
  import gwf_pkg::*;
(
  input  logic [COORD_W-1:0] base_row,
  input  logic [COORD_W-1:0] base_col,
  input  dir_t               dir,
  output logic [COORD_W-1:0] tgt_row,
  output logic [COORD_W-1:0] tgt_col,
  output logic [ADDR_W-1:0]  addr
);

  always_comb begin
    tgt_row = base_row;
    tgt_col = base_col;
    case (dir)
      DIR_DOWN:  tgt_row = base_row + COORD_W'(1);
      DIR_RIGHT: tgt_col = base_col + COORD_W'(1);
      DIR_UP:    tgt_row = base_row - COORD_W'(1);
      DIR_LEFT:  tgt_col = base_col - COORD_W'(1);
      default: ;
    endcase
  end

  // Row-major address; the multiply is by a constant.
  assign addr = ADDR_W'(tgt_row) * ADDR_W'(SIDE) + ADDR_W'(tgt_col);

endmodule

[rtl/gwf_checker.sv]
// ----------------------------------------------------------------------------
// gwf_checker: port-level checks for the grid wall follower
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module gwf_checker
  import gwf_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [IN_TDATA_W-1:0]  s_tdata,
  input logic [IN_TUSER_W-1:0]  s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // A result that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Every request leaves IDLE to be worked on, so ready drops after acceptance.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted on consecutive cycles");

  // A move is only reported together with an ok status.
  a_moved_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[10] |-> m_tdata[13:11] == ST_OK)
    else $error("move reported with a non-ok status");

  // The walker never leaves the grid and the status is a defined code.
  a_in_grid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, m_tdata[3:0]} < (COORD_W + 1)'(SIDE)) &&
                 ({1'b0, m_tdata[7:4]} < (COORD_W + 1)'(SIDE)) &&
                 (m_tdata[13:11] <= ST_NOT_STARTED))
    else $error("walker position or status out of range");

endmodule

bind grid_wall_follower_step gwf_checker u_gwf_checker (.*);

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: stream-level check of the grid wall follower
// Drives load, start and step requests over the slave stream, predicts every
// walker report in a scoreboard that keeps its own grid and walker state,
// and compares each report on the master stream field by field. The run
// covers directed corner cases, then random mazes under three idling modes,
// including a long receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module testbench;
  import gwf_pkg::*;

  localparam int ITEM_TARGET = 1900;
  // Cycles without any handshake before the run is declared hung. The limit
  // lies well above the receiver hold-off below.
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  // Heading codes: the direction of the last move.
  localparam logic [1:0] HEAD_RIGHT = 2'd0;
  localparam logic [1:0] HEAD_UP    = 2'd1;
  localparam logic [1:0] HEAD_LEFT  = 2'd2;
  localparam logic [1:0] HEAD_DOWN  = 2'd3;

  // One walker report as it sits in m_tdata, pos_row in the lowest bits.
  typedef struct packed {
    logic [2:0] status;
    logic       moved;
    logic [1:0] heading;
    logic [3:0] pos_col;
    logic [3:0] pos_row;
  } walker_report_t;

  localparam int REPORT_W = $bits(walker_report_t);

  // Scoreboard: tracks the grid and the walker as the block should, and
  // holds the reports still owed by the block, oldest first.
  class walker_board;
    bit             wall_at [CELLS];
    bit             seen_at [CELLS];
    logic [3:0]     row_q;
    logic [3:0]     col_q;
    logic [1:0]     head_q;
    bit             started_q;
    status_t        last_status;
    walker_report_t owed[$];
    int             failures;

    function new();
      row_q       = '0;
      col_q       = '0;
      head_q      = HEAD_RIGHT;
      started_q   = 1'b0;
      last_status = ST_NOT_STARTED;
      failures    = 0;
    endfunction

    function int cell_index(int r, int c);
      return r * SIDE + c;
    endfunction

    function void enter_cell(int r, int c);
      row_q = 4'(r);
      col_q = 4'(c);
      seen_at[cell_index(r, c)] = 1'b1;
    endfunction

    // Column 0 scan: the last open row between the corners is the entrance.
    function status_t scan_entrance();
      int found;
      found = -1;
      for (int r = 1; r < SIDE - 1; r++) begin
        if (!wall_at[cell_index(r, 0)]) found = r;
      end
      if (found < 0) begin
        started_q = 1'b0;
        return ST_NO_ENTRY;
      end
      enter_cell(found, 0);
      head_q    = HEAD_RIGHT;
      started_q = 1'b1;
      return ST_OK;
    endfunction

    // One move attempt of the right-hand rule.
    function status_t take_step(output logic moved);
      int r, c, nr, nc;
      logic [1:0] nh;
      r     = row_q;
      c     = col_q;
      nr    = r;
      nc    = c;
      nh    = HEAD_RIGHT;
      moved = 1'b0;
      if (!started_q) return ST_NOT_STARTED;
      // Standing on the visited entrance: leave it to the right if possible,
      // otherwise the walker has come back.
      if (c == 0 && seen_at[cell_index(r, 0)]) begin
        if (!wall_at[cell_index(r, 1)] && !seen_at[cell_index(r, 1)]) begin
          enter_cell(r, 1);
          moved = 1'b1;
          return ST_OK;
        end
        return ST_ENTRANCE;
      end
      if (r == 0 || r == SIDE - 1 || c == 0 || c == SIDE - 1) return ST_EXIT;
      case (head_q)
        HEAD_RIGHT: begin nr = r + 1; nh = HEAD_DOWN;  end
        HEAD_UP:    begin nc = c + 1; nh = HEAD_RIGHT; end
        HEAD_LEFT:  begin nr = r - 1; nh = HEAD_UP;    end
        default:    begin nc = c - 1; nh = HEAD_LEFT;  end
      endcase
      if (!wall_at[cell_index(nr, nc)]) begin
        enter_cell(nr, nc);
        head_q = nh;
        moved  = 1'b1;
      end else begin
        head_q = head_q + 2'd1;
      end
      return ST_OK;
    endfunction

    // Called for every request accepted on the slave stream.
    function void note_request(logic [1:0] op, logic [3:0] row, logic [3:0] col,
                               logic wall);
      walker_report_t rep;
      status_t        st;
      logic           moved;
      moved = 1'b0;
      case (op)
        OP_START: st = scan_entrance();
        OP_STEP:  st = take_step(moved);
        default: begin
          if (op == OP_LOAD && row < SIDE && col < SIDE) begin
            wall_at[cell_index(row, col)] = wall;
            seen_at[cell_index(row, col)] = 1'b0;
          end
          st = started_q ? ST_OK : ST_NOT_STARTED;
        end
      endcase
      rep.pos_row = row_q;
      rep.pos_col = col_q;
      rep.heading = head_q;
      rep.moved   = moved;
      rep.status  = st;
      owed.push_back(rep);
      last_status = st;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    // Called for every report accepted on the master stream.
    function void check_result(logic [OUT_TDATA_W-1:0] data);
      walker_report_t got, want;
      got = data[REPORT_W-1:0];
      if (owed.size() == 0) begin
        $error("report %h arrived with no request waiting", data);
        failures++;
        return;
      end
      want = owed.pop_front();
      compare_field("pos_row", 8'(want.pos_row), 8'(got.pos_row));
      compare_field("pos_col", 8'(want.pos_col), 8'(got.pos_col));
      compare_field("heading", 8'(want.heading), 8'(got.heading));
      compare_field("moved", 8'(want.moved), 8'(got.moved));
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("padding", 8'h00, 8'(data[OUT_TDATA_W-1:REPORT_W]));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid;
  logic                   s_tready;
  // s_tdata from bit 0 up: cell_row[3:0], cell_col[7:4], is_wall[8], zeros.
  logic [IN_TDATA_W-1:0]  s_tdata;
  // s_tuser from bit 0 up: opcode[1:0].
  logic [IN_TUSER_W-1:0]  s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  // m_tdata from bit 0 up: pos_row[3:0], pos_col[7:4], heading[9:8],
  // moved[10], status[13:11], zeros.
  logic [OUT_TDATA_W-1:0] m_tdata;

  walker_board board;
  int          requests_sent = 0;
  int          send_idle = 36;  // percent of cycles the sender holds back
  int          recv_idle = 87;  // percent of cycles the receiver stalls
  logic        hold_req = 1'b0; // asks the receiver for a long hold-off
  int          quiet_cycles = 0;

  grid_wall_follower_step dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Report monitor. Sampling at the rising edge sees the values from before
  // the edge, since the block updates its outputs through its flops.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  // Watchdog: a long stretch with no handshake on either side means a hang.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: stalls at random, or for a long counted stretch on request.
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Offers one request and returns at the falling edge after it was accepted,
  // with s_tvalid still high so that back-to-back requests leave no gap.
  task automatic offer_request(input logic [1:0] op, input logic [3:0] row,
                               input logic [3:0] col, input logic wall);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(IN_TDATA_W - 9){1'b0}}, wall, col, row};
    do @(posedge clk); while (!s_tready);
    board.note_request(op, row, col, wall);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic load_cell(input int r, input int c, input logic wall);
    offer_request(OP_LOAD, 4'(r), 4'(c), wall);
  endtask

  // Step requests carry random ignored content in tdata.
  task automatic step_walker();
    offer_request(OP_STEP, 4'($urandom_range(15)), 4'($urandom_range(15)),
                  1'($urandom_range(1)));
  endtask

  // Sender pause: nothing more is offered until every report is back.
  task automatic wait_for_reports();
    s_tvalid <= 1'b0;
    while (board.owed.size() != 0) @(negedge clk);
  endtask

  // Writes every cell once, so that no later request can read a cell that
  // was never loaded. Border walls, an open interior with one wall segment,
  // and column 0 closed so that the first start finds no entrance.
  task automatic load_whole_grid();
    bit border;
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        border = (r == 0 || r == SIDE - 1 || c == 0 || c == SIDE - 1);
        load_cell(r, c, border || (r == 3 && c >= 3 && c <= 8));
      end
    end
  endtask

  // New random maze on top of the old one: column 0 is rewritten so that the
  // entrance moves (or vanishes now and then), and a batch of other cells is
  // redrawn, border cells mostly wall so that exits are rare holes.
  task automatic reshape_maze();
    bit closed;
    bit w;
    int opened, r, c;
    closed = ($urandom_range(9) == 0);
    opened = 0;
    load_cell(0, 0, 1'b1);
    load_cell(SIDE - 1, 0, 1'b1);
    for (r = 1; r < SIDE - 1; r++) begin
      w = closed ? 1'b1 : ($urandom_range(3) != 0);
      if (!closed && r == SIDE - 2 && opened == 0) w = 1'b0;
      if (!w) opened++;
      load_cell(r, 0, w);
    end
    repeat (30) begin
      r = $urandom_range(SIDE - 1);
      c = $urandom_range(SIDE - 1, 1);
      if (r == 0 || r == SIDE - 1 || c == SIDE - 1) begin
        w = ($urandom_range(99) < 85);
      end else begin
        w = ($urandom_range(99) < 30);
      end
      load_cell(r, c, w);
    end
  endtask

  // One random maze: reshape, start, then walk until three non-ok reports
  // or 150 requests. A few noise requests of any kind, out-of-range
  // coordinates included, are mixed into the walk.
  task automatic run_maze_round(input bit squeeze);
    int n, extra;
    reshape_maze();
    // The hold-off starts while the walk requests keep coming, so the block
    // fills its output register and stops accepting.
    if (squeeze) hold_req <= 1'b1;
    offer_request(OP_START, 4'($urandom_range(15)), 4'($urandom_range(15)),
                  1'($urandom_range(1)));
    n     = 0;
    extra = 0;
    while (n < 150 && extra < 3) begin
      if ($urandom_range(99) < 8) begin
        offer_request(2'($urandom_range(3)), 4'($urandom_range(15)),
                      4'($urandom_range(15)), 1'($urandom_range(1)));
      end else begin
        step_walker();
      end
      if (board.last_status != ST_OK) extra++;
      n++;
    end
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    send_idle <= sender_pct;
    recv_idle <= receiver_pct;
  endtask

  initial begin
    board    = new();
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Before any cell is loaded: a step before start, the unused opcode and
    // loads whose row or column lies outside the grid all leave the state
    // alone and report the walker as not started.
    step_walker();
    offer_request(OP_UNUSED, 4'd11, 4'd11, 1'b1);
    load_cell(15, 15, 1'b1);
    load_cell(SIDE, 3, 1'b0);
    load_cell(3, SIDE, 1'b1);

    load_whole_grid();

    // Column 0 is all wall: no entrance, and later steps see no start.
    offer_request(OP_START, 4'd0, 4'd0, 1'b0);
    step_walker();
    offer_request(OP_UNUSED, 4'd0, 4'd15, 1'b0);

    // Two open rows; the scan must pick the lower one.
    load_cell(4, 0, 1'b0);
    load_cell(7, 0, 1'b0);
    offer_request(OP_START, 4'd15, 4'd15, 1'b1);
    repeat (12) step_walker();
    offer_request(OP_UNUSED, 4'd15, 4'd15, 1'b1);

    // Wall right of the entrance: the walker is back at the entrance, twice.
    load_cell(7, 1, 1'b1);
    offer_request(OP_START, 4'd0, 4'd0, 1'b0);
    step_walker();
    step_walker();
    // Reopened cell is unvisited again, so the entrance step moves right.
    load_cell(7, 1, 1'b0);
    step_walker();
    step_walker();

    // Random mazes, first with the sender sparse and the receiver slow.
    run_maze_round(1'b1);
    while (requests_sent < ITEM_TARGET / 3) run_maze_round(1'b0);
    wait_for_reports();

    set_idling(87, 36);
    while (requests_sent < 2 * ITEM_TARGET / 3) run_maze_round(1'b0);
    wait_for_reports();

    set_idling(0, 0);
    while (requests_sent < ITEM_TARGET) run_maze_round(1'b0);

    // Drain, then keep the clock running so that any stray report would show.
    s_tvalid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (4 * SIDE) @(posedge clk);
    if (board.failures == 0 && board.owed.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
